### sv/wlav_pkg.sv
// Shared constants, codes and helper functions for the Wilson loop average block.
package wlav_pkg;

  localparam int unsigned MAX_X_DEF = 64;
  localparam int unsigned MAX_Y_DEF = 64;

  localparam int unsigned CFG_W   = 7;
  localparam int unsigned CFG_IW  = 2;
  localparam int unsigned SITE_W  = 6;
  localparam int unsigned Q_W     = 18;
  localparam int unsigned PROD_W  = 2 * Q_W;
  localparam int unsigned ACC_W   = 21;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned DIVD_W  = SUM_W + 1;

  localparam logic [CFG_IW-1:0] CFG_SIDE_X    = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_SIDE_Y    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_LATTICE_X = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_LATTICE_Y = 2'd3;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_MEASURE = 1'b1;

  localparam logic signed [Q_W-1:0] Q_ONE = 18'sd65536;
  localparam logic signed [Q_W-1:0] Q_MAX = 18'sd131071;
  localparam logic signed [Q_W-1:0] Q_MIN = -18'sd131072;

  // Clamp a signed accumulator to Q2.16 range.
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(Q_MAX);
    lo = ACC_W'(Q_MIN);
    if (v > hi) return Q_MAX;
    else if (v < lo) return Q_MIN;
    else return Q_W'(v);
  endfunction

  // Apply sign to an unsigned quotient magnitude and clamp to Q2.16.
  function automatic logic signed [Q_W-1:0] sat_mag(input logic neg,
                                                    input logic [DIVD_W-1:0] q);
    logic [DIVD_W-1:0] lim_pos;
    logic [DIVD_W-1:0] lim_neg;
    lim_pos = DIVD_W'(131071);
    lim_neg = DIVD_W'(131072);
    if (neg) begin
      if (q > lim_neg) return Q_MIN;
      else return Q_W'(-$signed({1'b0, q}));
    end else begin
      if (q > lim_pos) return Q_MAX;
      else return Q_W'(q);
    end
  endfunction

endpackage

### sv/wilson_loop_average.sv
// Top level: link store, loop walk sequencer with shared multiplier, and mean output.
//
// Load items (action 0) write one link into the on-chip store; loads stream at one per
// cycle while the block is idle. A measure item (action 1) walks every site of the
// lattice in use, x outer and y inner; at each site it multiplies 2*(side_x+side_y)
// links through one 18x18 multiplier, four products per link. Each link takes a leg
// control step, a store read and five multiply/accumulate steps; each site adds site
// setup, one leg turn per leg and the sum. The final mean takes two divisions by the
// site count (start, 33 quotient bits, done) and then a hand-over of the mean to the
// output register; the block waits there while an earlier mean is still stalled. Input
// is stalled for the whole measurement. The store holds no reset value: every link a
// measurement visits must be loaded first.
module wilson_loop_average #(
  parameter int unsigned MAX_X = wlav_pkg::MAX_X_DEF,
  parameter int unsigned MAX_Y = wlav_pkg::MAX_Y_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wlav_pkg::CFG_IW-1:0]       cfg_index_i,
  input  logic [wlav_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [wlav_pkg::SITE_W-1:0]       site_x_i,
  input  logic [wlav_pkg::SITE_W-1:0]       site_y_i,
  input  logic                              direction_i,
  input  logic signed [wlav_pkg::Q_W-1:0]   link_re_i,
  input  logic signed [wlav_pkg::Q_W-1:0]   link_im_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [wlav_pkg::Q_W-1:0]   mean_re_o,
  output logic signed [wlav_pkg::Q_W-1:0]   mean_im_o
);
  import wlav_pkg::*;

  localparam int unsigned DEPTH = MAX_X * MAX_Y * 2;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = $clog2(MAX_X);
  localparam int unsigned YW    = $clog2(MAX_Y);
  localparam int unsigned NXW   = $clog2(MAX_X + 1);
  localparam int unsigned NYW   = $clog2(MAX_Y + 1);
  localparam int unsigned CW    = NXW + NYW;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SITE   = 11'b00000000010,
    S_LEG    = 11'b00000000100,
    S_ADDR   = 11'b00000001000,
    S_MUL    = 11'b00000010000,
    S_ACC    = 11'b00000100000,
    S_DST_RE = 11'b00001000000,
    S_DWT_RE = 11'b00010000000,
    S_DST_IM = 11'b00100000000,
    S_DWT_IM = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_W-1:0] side_x_q, side_y_q, lat_x_q, lat_y_q;

  logic [NXW-1:0] nx;
  logic [NYW-1:0] ny;

  always_comb begin
    if (lat_x_q == '0) nx = NXW'(1);
    else if (32'(lat_x_q) > MAX_X) nx = NXW'(MAX_X);
    else nx = NXW'(lat_x_q);
    if (lat_y_q == '0) ny = NYW'(1);
    else if (32'(lat_y_q) > MAX_Y) ny = NYW'(MAX_Y);
    else ny = NYW'(lat_y_q);
  end

  // Link store.
  logic [PROD_W-1:0] mem [DEPTH];
  logic [PROD_W-1:0] rd_q;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic              in_acc, load_we;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_we    = in_acc && (action_i == ACT_LOAD)
                      && (32'(site_x_i) < MAX_X) && (32'(site_y_i) < MAX_Y);
  assign wr_addr    = AW'((32'(site_y_i) * MAX_X + 32'(site_x_i)) * 2 + 32'(direction_i));

  logic [XW-1:0] x_q, cx_q;
  logic [YW-1:0] y_q, cy_q;
  logic [1:0]    leg_q;
  logic [CFG_W-1:0] n_q;
  logic [2:0]    ph_q;

  assign rd_addr = AW'((32'(cy_q) * MAX_X + 32'(cx_q)) * 2 + 32'(leg_q[0]));

  always_ff @(posedge clk_i) begin
    if (load_we) mem[wr_addr] <= {link_re_i, link_im_i};
    if (state_q == S_ADDR) rd_q <= mem[rd_addr];
  end

  // Shared multiplier datapath.
  logic signed [Q_W-1:0]    wr_q, wi_q, op_a, op_b, br, bi;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W:0]   prod_rnd;
  logic signed [ACC_W-1:0]  rnd, acc_re_q, acc_im_q, acc_im_fin;
  logic                     conj;

  assign br       = rd_q[PROD_W-1:Q_W];
  assign bi       = rd_q[Q_W-1:0];
  assign op_a     = ph_q[0] ? wi_q : wr_q;
  assign op_b     = (ph_q[0] ^ ph_q[1]) ? bi : br;
  assign prod_rnd = (PROD_W+1)'(prod_q) + (PROD_W+1)'(32768);
  assign rnd      = ACC_W'(prod_rnd >>> 16);
  assign conj     = leg_q[1];
  assign acc_im_fin = acc_im_q + rnd;

  logic [CFG_W-1:0] side_cur;
  assign side_cur = leg_q[0] ? side_y_q : side_x_q;

  logic signed [SUM_W-1:0] sum_re_q, sum_im_q;
  logic [CW-1:0]           cnt_q;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [Q_W-1:0] v);
    logic signed [SUM_W:0] t;
    t = (SUM_W+1)'(s) + (SUM_W+1)'(v);
    if (t[SUM_W] != t[SUM_W-1]) return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                : {1'b0, {(SUM_W-1){1'b1}}};
    else return t[SUM_W-1:0];
  endfunction

  // Divider interface.
  logic                  div_start, div_done;
  logic [DIVD_W-1:0]     div_q, dvd_q;
  logic signed [SUM_W-1:0] sum_sel;
  logic                  neg_q;
  logic [DIVD_W-1:0]     mag;

  assign sum_sel = (state_q == S_DST_IM) ? sum_im_q : sum_re_q;
  assign mag     = sum_sel[SUM_W-1] ? DIVD_W'(-(DIVD_W'(sum_sel))) : DIVD_W'(sum_sel);
  assign dvd_q   = mag + DIVD_W'(cnt_q >> 1);
  assign div_start = (state_q == S_DST_RE) || (state_q == S_DST_IM);

  wlav_div #(.CW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  logic             out_valid_q;
  logic signed [Q_W-1:0] mean_re_q, mean_im_q, re_hold_q;
  logic             out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc && action_i == ACT_MEASURE) state_d = S_SITE;
      S_SITE:   state_d = S_LEG;
      S_LEG:    begin
        if (n_q == side_cur) state_d = (leg_q == 2'd3) ? S_ACC : S_LEG;
        else state_d = S_ADDR;
      end
      S_ADDR:   state_d = S_MUL;
      S_MUL:    if (ph_q == 3'd4) state_d = S_LEG;
      S_ACC:    begin
        if (NYW'(y_q) + 1'b1 == ny && NXW'(x_q) + 1'b1 == nx) state_d = S_DST_RE;
        else state_d = S_SITE;
      end
      S_DST_RE: state_d = S_DWT_RE;
      S_DWT_RE: if (div_done) state_d = S_DST_IM;
      S_DST_IM: state_d = S_DWT_IM;
      S_DWT_IM: if (div_done) state_d = S_OUT;
      // Hold the finished mean until the output register is free.
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      side_x_q    <= CFG_W'(1);
      side_y_q    <= CFG_W'(1);
      lat_x_q     <= CFG_W'(64);
      lat_y_q     <= CFG_W'(64);
      out_valid_q <= 1'b0;
      sum_re_q    <= '0;
      sum_im_q    <= '0;
      ph_q        <= '0;
      leg_q       <= '0;
      n_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SIDE_X:    side_x_q <= cfg_data_i;
          CFG_SIDE_Y:    side_y_q <= cfg_data_i;
          CFG_LATTICE_X: lat_x_q  <= cfg_data_i;
          CFG_LATTICE_Y: lat_y_q  <= cfg_data_i;
          default:       ;
        endcase
      end
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == S_IDLE && in_acc && action_i == ACT_MEASURE) begin
        sum_re_q <= '0;
        sum_im_q <= '0;
      end
      if (state_q == S_ACC) begin
        sum_re_q <= sat_add(sum_re_q, wr_q);
        sum_im_q <= sat_add(sum_im_q, wi_q);
      end
      if (state_q == S_SITE) begin
        leg_q <= '0;
        n_q   <= '0;
      end
      if (state_q == S_LEG && n_q == side_cur && leg_q != 2'd3) begin
        leg_q <= leg_q + 1'b1;
        n_q   <= '0;
      end
      if (state_q == S_ADDR) ph_q <= '0;
      if (state_q == S_MUL) begin
        ph_q <= ph_q + 1'b1;
        if (ph_q == 3'd4) n_q <= n_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc && action_i == ACT_MEASURE) begin
      x_q   <= '0;
      y_q   <= '0;
      cnt_q <= CW'(nx) * CW'(ny);
    end
    if (state_q == S_SITE) begin
      wr_q <= Q_ONE;
      wi_q <= '0;
      cx_q <= x_q;
      cy_q <= y_q;
    end
    // Step back before the read on the return legs.
    if (state_q == S_LEG && n_q != side_cur && leg_q[1]) begin
      if (leg_q[0]) cy_q <= (cy_q == '0) ? YW'(ny - 1'b1) : cy_q - 1'b1;
      else          cx_q <= (cx_q == '0) ? XW'(nx - 1'b1) : cx_q - 1'b1;
    end
    if (state_q == S_MUL) begin
      prod_q <= op_a * op_b;
      case (ph_q)
        3'd1: acc_re_q <= rnd;
        3'd2: acc_re_q <= conj ? acc_re_q + rnd : acc_re_q - rnd;
        3'd3: acc_im_q <= conj ? -rnd : rnd;
        3'd4: begin
          wr_q <= sat_q(acc_re_q);
          wi_q <= sat_q(acc_im_fin);
          // Advance after the multiply on the outgoing legs.
          if (!leg_q[1]) begin
            if (leg_q[0]) cy_q <= (NYW'(cy_q) + 1'b1 == ny) ? '0 : cy_q + 1'b1;
            else          cx_q <= (NXW'(cx_q) + 1'b1 == nx) ? '0 : cx_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (state_q == S_ACC) begin
      if (NYW'(y_q) + 1'b1 == ny) begin
        y_q <= '0;
        x_q <= x_q + 1'b1;
      end else begin
        y_q <= y_q + 1'b1;
      end
    end
    if (div_start) neg_q <= sum_sel[SUM_W-1];
    if (state_q == S_DWT_RE && div_done) re_hold_q <= sat_mag(neg_q, div_q);
    // The divider holds its quotient while idle.
    if (state_q == S_OUT && out_free) begin
      mean_re_q <= re_hold_q;
      mean_im_q <= sat_mag(neg_q, div_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign mean_re_o   = mean_re_q;
  assign mean_im_o   = mean_im_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i == ACT_LOAD) |=> state_q == S_IDLE)
    else $error("load left idle");
  a_mul_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> ph_q <= 3'd4) else $error("multiply phase overrun");
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DWT_RE || state_q == S_DWT_IM))
    else $error("divider done outside wait");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(mean_re_q)
                                      && $stable(mean_im_q)))
    else $error("stalled mean changed");

endmodule

### sv/wlav_div.sv
// Restoring divider, one quotient bit per cycle.
module wlav_div #(
  parameter int unsigned CW = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [wlav_pkg::DIVD_W-1:0]   dividend_i,
  input  logic [CW-1:0]                 divisor_i,
  output logic                          done_o,
  output logic [wlav_pkg::DIVD_W-1:0]   quotient_o
);
  import wlav_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVD_W + 1);

  logic [CW:0]         rem_q, rem_d;
  logic [DIVD_W-1:0]   quo_q, quo_d;
  logic [CW-1:0]       dsr_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CW:0]         shifted;

  assign shifted = {rem_q[CW-1:0], quo_q[DIVD_W-1]};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = shifted - {1'b0, dsr_q};
        quo_d = {quo_q[DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[DIVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) dsr_q <= divisor_i;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < CNT_W'(DIVD_W)) else $error("divider count overrun");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");

endmodule

### tb/sv/wlav_checker.sv
// Checker: watches the ports of the Wilson loop average block, predicts each mean and compares it.
module wlav_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wlav_pkg::CFG_IW-1:0]     cfg_index_i,
  input  logic [wlav_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [wlav_pkg::SITE_W-1:0]     site_x_i,
  input  logic [wlav_pkg::SITE_W-1:0]     site_y_i,
  input  logic                            direction_i,
  input  logic signed [wlav_pkg::Q_W-1:0] link_re_i,
  input  logic signed [wlav_pkg::Q_W-1:0] link_im_i,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic signed [wlav_pkg::Q_W-1:0] mean_re_o,
  input  logic signed [wlav_pkg::Q_W-1:0] mean_im_o,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              means_seen_o
);
  import wlav_pkg::*;

  localparam int LX = 64;
  localparam int LY = 64;

  typedef struct packed {
    logic signed [Q_W-1:0] re;
    logic signed [Q_W-1:0] im;
  } mean_t;

  logic signed [Q_W-1:0] link_re_mem [LX*LY*2];
  logic signed [Q_W-1:0] link_im_mem [LX*LY*2];
  logic [CFG_W-1:0] side_x, side_y, lat_x, lat_y;
  mean_t means_due [$];

  function automatic longint sat18(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic longint rnd16(longint p);
    return (p + 32768) >>> 16;
  endfunction

  function automatic int link_addr(int x, int y, int d);
    return (y * LX + x) * 2 + d;
  endfunction

  // Multiply the running product by a stored link, or by its conjugate.
  task automatic mul_link(inout longint wr, inout longint wi, input int a, input bit conj);
    longint br, bi, rr, ii, ri, ir;
    br = link_re_mem[a];
    bi = link_im_mem[a];
    rr = rnd16(wr * br);
    ii = rnd16(wi * bi);
    ri = rnd16(wr * bi);
    ir = rnd16(wi * br);
    if (conj) begin
      wr = sat18(rr + ii);
      wi = sat18(ir - ri);
    end else begin
      wr = sat18(rr - ii);
      wi = sat18(ri + ir);
    end
  endtask

  function automatic longint div_near(longint s, longint n);
    if (s >= 0) return (s + n / 2) / n;
    return -((-s + n / 2) / n);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic loop_mean(output mean_t m);
    int nx, ny, cx, cy;
    longint wr, wi, sr, si, cnt;
    nx = (lat_x == 0) ? 1 : (lat_x > LX) ? LX : lat_x;
    ny = (lat_y == 0) ? 1 : (lat_y > LY) ? LY : lat_y;
    sr = 0;
    si = 0;
    for (int x = 0; x < nx; x++) begin
      for (int y = 0; y < ny; y++) begin
        wr = 65536;
        wi = 0;
        cx = x;
        cy = y;
        for (int n = 0; n < side_x; n++) begin
          mul_link(wr, wi, link_addr(cx, cy, 0), 1'b0);
          cx = (cx + 1) % nx;
        end
        for (int n = 0; n < side_y; n++) begin
          mul_link(wr, wi, link_addr(cx, cy, 1), 1'b0);
          cy = (cy + 1) % ny;
        end
        for (int n = 0; n < side_x; n++) begin
          cx = (cx + nx - 1) % nx;
          mul_link(wr, wi, link_addr(cx, cy, 0), 1'b1);
        end
        for (int n = 0; n < side_y; n++) begin
          cy = (cy + ny - 1) % ny;
          mul_link(wr, wi, link_addr(cx, cy, 1), 1'b1);
        end
        sr = sat32(sr + wr);
        si = sat32(si + wi);
      end
    end
    cnt = nx * ny;
    m.re = Q_W'(sat18(div_near(sr, cnt)));
    m.im = Q_W'(sat18(div_near(si, cnt)));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mean_t m;
    if (!rst_ni) begin
      side_x <= 7'd1;
      side_y <= 7'd1;
      lat_x  <= 7'd64;
      lat_y  <= 7'd64;
      means_due.delete();
      for (int i = 0; i < LX * LY * 2; i++) begin
        link_re_mem[i] = '0;
        link_im_mem[i] = '0;
      end
      fail_count_o = 0;
      means_seen_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SIDE_X:    side_x <= cfg_data_i;
          CFG_SIDE_Y:    side_y <= cfg_data_i;
          CFG_LATTICE_X: lat_x  <= cfg_data_i;
          CFG_LATTICE_Y: lat_y  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        if (action_i == ACT_LOAD) begin
          link_re_mem[link_addr(site_x_i, site_y_i, direction_i)] = link_re_i;
          link_im_mem[link_addr(site_x_i, site_y_i, direction_i)] = link_im_i;
        end else begin
          loop_mean(m);
          means_due.insert(means_due.size(), m);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        means_seen_o++;
        if (means_due.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected mean re=%0d im=%0d", $time, mean_re_o, mean_im_o);
        end else begin
          m = means_due.pop_front();
          if (mean_re_o !== m.re) begin
            fail_count_o++;
            $display("%0t: mean_re expected %0d got %0d", $time, m.re, mean_re_o);
          end
          if (mean_im_o !== m.im) begin
            fail_count_o++;
            $display("%0t: mean_im expected %0d got %0d", $time, m.im, mean_im_o);
          end
        end
      end
      pending_o <= means_due.size();
    end
  end
endmodule

### tb/sv/testbench.sv
// Testbench top: clock, reset, stimulus for loads and measurements, watchdog and verdict.
module testbench;
  import wlav_pkg::*;

  localparam int WATCH_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IW-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = ACT_LOAD;
  logic [SITE_W-1:0] site_x_i = '0;
  logic [SITE_W-1:0] site_y_i = '0;
  logic direction_i = 1'b0;
  logic signed [Q_W-1:0] link_re_i = '0;
  logic signed [Q_W-1:0] link_im_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [Q_W-1:0] mean_re_o, mean_im_o;
  int fail_count, pending, means_seen;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int n_loads = 0;
  int n_measures = 0;
  int idle_run = 0;

  always #6 clk_i = ~clk_i;

  wilson_loop_average DUT (.*);

  wlav_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .action_i, .site_x_i, .site_y_i, .direction_i, .link_re_i, .link_im_i,
    .out_valid_o, .out_stall_i, .mean_re_o, .mean_im_o,
    .fail_count_o(fail_count), .pending_o(pending), .means_seen_o(means_seen)
  );

  // Receiver: long hold-off when requested, random stalls otherwise.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= WATCH_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(input logic act, input int sx, input int sy, input int d,
                      input logic [Q_W-1:0] re, input logic [Q_W-1:0] im);
    int gap;
    in_valid_i  <= 1'b1;
    action_i    <= act;
    site_x_i    <= SITE_W'(sx);
    site_y_i    <= SITE_W'(sy);
    direction_i <= 1'(d);
    link_re_i   <= re;
    link_im_i   <= im;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (act == ACT_LOAD) n_loads++;
    else n_measures++;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load(input int sx, input int sy, input int d,
                      input logic [Q_W-1:0] re, input logic [Q_W-1:0] im);
    send(ACT_LOAD, sx, sy, d, re, im);
  endtask

  task automatic measure();
    send(ACT_MEASURE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1),
         Q_W'($urandom), Q_W'($urandom));
  endtask

  // Hold the sender until every expected mean has arrived, then let loads settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_geometry(input int sx, input int sy, input int lx, input int ly);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_SIDE_X;
    cfg_data_i <= CFG_W'(sx);
    @(posedge clk_i);
    cfg_index_i <= CFG_SIDE_Y;
    cfg_data_i <= CFG_W'(sy);
    @(posedge clk_i);
    cfg_index_i <= CFG_LATTICE_X;
    cfg_data_i <= CFG_W'(lx);
    @(posedge clk_i);
    cfg_index_i <= CFG_LATTICE_Y;
    cfg_data_i <= CFG_W'(ly);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [Q_W-1:0] rand_link();
    case ($urandom_range(0, 5))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return Q_ONE;
      default: return Q_W'($urandom);
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every link of the 8x8 corner so any lattice up to 8x8 reads written data.
    for (int y = 0; y < 8; y++)
      for (int x = 0; x < 8; x++)
        for (int d = 0; d < 2; d++)
          load(x, y, d, rand_link(), rand_link());

    // Directed: size zero used as one, clamped large lattice with empty loop, long sides.
    set_geometry(1, 1, 0, 0);
    measure();
    set_geometry(0, 0, 127, 127);
    measure();
    set_geometry(0, 0, 64, 64);
    measure();
    set_geometry(127, 0, 2, 2);
    measure();
    set_geometry(0, 127, 3, 1);
    measure();
    set_geometry(127, 127, 2, 1);
    measure();
    load(0, 0, 0, Q_MAX, Q_MAX);
    load(0, 0, 1, Q_MIN, Q_MIN);
    load(7, 7, 0, Q_MIN, Q_MAX);
    load(7, 7, 1, Q_MAX, Q_MIN);
    load(63, 63, 0, Q_MAX, Q_MIN);
    load(63, 63, 1, '0, '0);
    load(40, 20, 1, Q_ONE, '0);
    set_geometry(2, 3, 8, 8);
    measure();

    // Pressure: receiver holds off past two measurements, so the second mean waits
    // inside the block and the third measure is stalled.
    set_geometry(1, 2, 3, 3);
    hold_cycles = 1500;
    measure();
    for (int i = 0; i < 6; i++) load($urandom_range(0, 7), $urandom_range(0, 7),
                                     $urandom_range(0, 1), rand_link(), rand_link());
    measure();
    measure();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int k = 0; k < 2; k++) begin
        set_geometry($urandom_range(0, 3), $urandom_range(0, 3),
                     $urandom_range(1, 8), $urandom_range(1, 8));
        for (int i = 0; i < 40; i++) begin
          if ($urandom_range(0, 99) < 12) measure();
          else if ($urandom_range(0, 99) < 70)
            load($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 1),
                 rand_link(), rand_link());
          else
            load($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1),
                 rand_link(), rand_link());
        end
        measure();
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("ran %0d link loads and %0d measurements, %0d means checked", n_loads,
             n_measures, means_seen);
    $display("covered empty, clamped, wrapping and long loops under stalls and gaps");
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
